FILE: hdl/dq_pkg.sv
package dq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_PEEK_BACK  = 3'd4,
      OP_PEEK_FRONT = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // shift controls broadcast to every cell, already qualified by full/empty
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
   } cell_ctrl_type;

endpackage

FILE: hdl/double_ended_queue_core.sv
// Double-ended queue of 32-bit words held in a row of DEPTH word cells.
// Cell 0 always holds the front word; the back word sits in cell count-1.
// Request channel (req_): tuser carries the operation (push back/front,
// pop back/front, peek back/front, clear), tdata the word to push.
// Result channel (rsp_): one item per request with the popped or peeked
// word (zero otherwise), the fill count after the operation and a status
// of ok, empty (pop/peek with nothing stored) or full (push at DEPTH).
// Push front and pop front shift the whole row by one cell at once;
// push back writes the cell at the fill count.
// The result of an accepted request is registered in the output buffer.
// Throughput: one request per cycle while req_tready is high.
// A two-entry output buffer lets one more request in after the result
// side stalls; req_tready then drops until it drains.
// Reset clears the fill count and the output buffer; cell contents are
// not cleared and are only read after being written.
module double_ended_queue_core #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int RSP_W = ((dq_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dq_pkg::WORD_W-1:0]   req_tdata,  // data_in[31:0]
   input  logic [dq_pkg::OP_W-1:0]     req_tuser,  // opcode[2:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_W-1:0]            rsp_tdata,  // data_out[31:0], fill_count, zero pad
   output logic [dq_pkg::STATUS_W-1:0] rsp_tuser   // status[1:0]
);
   import dq_pkg::*;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam int BUF_W = RSP_W + STATUS_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   cell_ctrl_type     ctrl;
   logic [WORD_W-1:0] cell_word [DEPTH];
   logic [WORD_W-1:0] cell_back [DEPTH];
   logic [WORD_W-1:0] back_word;
   logic [WORD_W-1:0] data_out;
   status_type        status;
   logic              accept;
   logic              is_empty, is_full;
   logic [BUF_W-1:0]  buf_in, buf_out;

   assign accept   = req_tvalid && req_tready;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == FULL_CNT);

   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | cell_back[i];
      end
   end

   always_comb begin
      ctrl     = '0;
      count_in = count_ff;
      data_out = '0;
      status   = ST_OK;
      unique case (req_tuser)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               ctrl.push_back  = (req_tuser == OP_PUSH_BACK);
               ctrl.push_front = (req_tuser == OP_PUSH_FRONT);
               count_in        = count_ff + 1'b1;
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               data_out = back_word;
               if (req_tuser == OP_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               data_out = cell_word[0];
               if (req_tuser == OP_POP_FRONT) begin
                  ctrl.pop_front = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!accept) begin
         ctrl     = '0;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      dq_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .left_word  ((g == 0) ? req_tdata : cell_word[(g == 0) ? 0 : g - 1]),
         .right_word ((g == DEPTH - 1) ? '0 : cell_word[(g == DEPTH - 1) ? g : g + 1]),
         .push_word  (req_tdata),
         .word       (cell_word[g]),
         .back_word  (cell_back[g])
      );
   end

   assign buf_in = {STATUS_W'(status), (RSP_W - WORD_W)'(count_in), data_out};

   dq_rsp_buf #(
      .W (BUF_W)
   ) u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (buf_in),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_out)
   );

   assign rsp_tdata = buf_out[RSP_W-1:0];
   assign rsp_tuser = buf_out[BUF_W-1:RSP_W];

endmodule

FILE: hdl/dq_cell.sv
module dq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                      clock,
   input  dq_pkg::cell_ctrl_type     ctrl,
   input  logic [CNT_W-1:0]          count,
   input  logic [dq_pkg::WORD_W-1:0] left_word,
   input  logic [dq_pkg::WORD_W-1:0] right_word,
   input  logic [dq_pkg::WORD_W-1:0] push_word,
   output logic [dq_pkg::WORD_W-1:0] word,
   output logic [dq_pkg::WORD_W-1:0] back_word
);
   import dq_pkg::*;

   localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.push_front) begin
         word_in = (INDEX == 0) ? push_word : left_word;
      end else if (ctrl.push_back && (count == IDX)) begin
         word_in = push_word;
      end else if (ctrl.pop_front) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign back_word = (count == IDX_P1) ? word_ff : '0;

endmodule

FILE: hdl/dq_rsp_buf.sv
module dq_rsp_buf #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic         out_valid_ff, out_valid_in;
   logic [W-1:0] out_data_ff, out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   logic [W-1:0] skid_data_ff, skid_data_in;
   logic         take;

   assign in_ready = !skid_valid_ff && !reset;
   assign take     = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: hdl/dq_checker.sv
module dq_checker #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int RSP_W = ((dq_pkg::WORD_W + CNT_W + 7) / 8) * 8
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [RSP_W-1:0]            rsp_tdata,
   input logic [dq_pkg::STATUS_W-1:0] rsp_tuser
);
   import dq_pkg::*;

   logic [CNT_W-1:0]  fill;
   logic [WORD_W-1:0] word;

   assign fill = rsp_tdata[WORD_W +: CNT_W];
   assign word = rsp_tdata[WORD_W-1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL) |-> (fill == CNT_W'(DEPTH)) && (word == '0))
      else $error("full status without full count");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> (fill == '0) && (word == '0))
      else $error("empty status with words stored");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fill <= CNT_W'(DEPTH)))
      else $error("fill count beyond depth");

endmodule

bind double_ended_queue_core dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
